/* rtl/core/mhpq_pkg.sv */
// Shared types and constants for the min-heap priority queue.
package mhpq_pkg;

  localparam int KEY_FIELD_W = 64;
  localparam int COUNT_W     = 11;

  typedef enum logic [0:0] {
    CmdInsert = 1'b0,
    CmdRemove = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [KEY_FIELD_W-1:0] smallest;
    logic                   heap_empty;
    logic [COUNT_W-1:0]     entry_count;
    status_e                status;
  } result_t;

endpackage

/* rtl/core/mhpq_if.sv */
// Valid/ready channel interfaces for heap commands and heap results.
interface mhpq_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic [mhpq_pkg::KEY_FIELD_W-1:0]     key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface mhpq_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [mhpq_pkg::KEY_FIELD_W-1:0]     smallest;
  logic                                 heap_empty;
  logic [mhpq_pkg::COUNT_W-1:0]         entry_count;
  logic [1:0]                           status;

  modport source (output valid, output smallest, output heap_empty, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input smallest, input heap_empty, input entry_count,
                  input status, output ready);
endinterface

/* rtl/core/mhpq_key_cmp.sv */
// Shared unsigned key comparator used by every sift step.
module mhpq_key_cmp #(
  parameter int KEY_W = 64
) (
  input  logic [KEY_W-1:0] a_i,
  input  logic [KEY_W-1:0] b_i,
  output logic             lt_o
);

  assign lt_o = (a_i < b_i);

endmodule

/* rtl/core/mhpq_engine.sv */
// Heap store and sift sequencer built around one shared key comparator.
module mhpq_engine #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_BYTES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  mhpq_pkg::cmd_e                   cmd_i,
  input  logic [mhpq_pkg::KEY_FIELD_W-1:0] key_i,
  output logic                             idle_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output mhpq_pkg::result_t                res_o
);

  localparam int KeyW   = 8 * KEY_BYTES;
  localparam int AddrW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int IdxW   = AddrW + 2;
  localparam int FieldW = mhpq_pkg::KEY_FIELD_W;
  localparam int CountW = mhpq_pkg::COUNT_W;

  typedef enum logic [3:0] {
    StIdle,
    StUpRead,
    StUpCmp,
    StRmLoad,
    StDnRead,
    StDnPick,
    StDnSwap,
    StDone
  } state_e;

  state_e                state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [AddrW-1:0]      pos_q, pos_d;
  logic [AddrW-1:0]      cidx_q, cidx_d;
  logic [KeyW-1:0]       key_q, key_d;
  logic [KeyW-1:0]       child_q, child_d;
  mhpq_pkg::status_e     status_q, status_d;

  logic [KeyW-1:0]       heap_mem_q [CAPACITY];
  logic [KeyW-1:0]       rd0_q, rd1_q;
  logic [KeyW-1:0]       root_q;
  logic [AddrW-1:0]      rd0_addr, rd1_addr;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [KeyW-1:0]       wr_data;

  logic [KeyW-1:0]       cmp_a, cmp_b;
  logic                  cmp_lt;

  logic [AddrW-1:0]      parent;
  logic [IdxW-1:0]       left_idx, right_idx, cnt_idx;
  logic                  right_ok;

  mhpq_key_cmp #(
    .KEY_W (KeyW)
  ) u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt)
  );

  assign parent    = (pos_q - AddrW'(1)) >> 1;
  assign left_idx  = {1'b0, pos_q, 1'b1};
  assign right_idx = left_idx + IdxW'(1);
  assign cnt_idx   = IdxW'(count_q);
  assign right_ok  = (right_idx < cnt_idx);

  always_comb begin
    unique case (state_q)
      StDnPick: begin
        cmp_a = rd1_q;
        cmp_b = rd0_q;
      end
      StDnSwap: begin
        cmp_a = child_q;
        cmp_b = key_q;
      end
      default: begin
        cmp_a = key_q;
        cmp_b = rd0_q;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    cidx_d   = cidx_q;
    key_d    = key_q;
    child_d  = child_q;
    status_d = status_q;
    rd0_addr = parent;
    rd1_addr = parent;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = key_q;
    unique case (state_q)
      StIdle: begin
        rd0_addr = AddrW'(count_q - CntW'(1));
        if (start_i) begin
          status_d = mhpq_pkg::StatusOk;
          if (cmd_i == mhpq_pkg::CmdInsert) begin
            if (count_q == CntW'(CAPACITY)) begin
              status_d = mhpq_pkg::StatusFull;
              state_d  = StDone;
            end else begin
              key_d   = key_i[KeyW-1:0];
              pos_d   = AddrW'(count_q);
              count_d = count_q + CntW'(1);
              state_d = StUpRead;
            end
          end else begin
            if (count_q == '0) begin
              status_d = mhpq_pkg::StatusEmpty;
              state_d  = StDone;
            end else begin
              count_d = count_q - CntW'(1);
              state_d = StRmLoad;
            end
          end
        end
      end
      StUpRead: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = StDone;
        end else begin
          state_d = StUpCmp;
        end
      end
      StUpCmp: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data = rd0_q;
          pos_d   = parent;
          state_d = StUpRead;
        end else begin
          state_d = StDone;
        end
      end
      StRmLoad: begin
        key_d   = rd0_q;
        pos_d   = '0;
        state_d = (count_q == '0) ? StDone : StDnRead;
      end
      StDnRead: begin
        rd0_addr = left_idx[AddrW-1:0];
        rd1_addr = right_ok ? right_idx[AddrW-1:0] : left_idx[AddrW-1:0];
        if (left_idx >= cnt_idx) begin
          wr_en   = 1'b1;
          state_d = StDone;
        end else begin
          state_d = StDnPick;
        end
      end
      StDnPick: begin
        child_d = cmp_lt ? rd1_q : rd0_q;
        cidx_d  = cmp_lt ? right_idx[AddrW-1:0] : left_idx[AddrW-1:0];
        state_d = StDnSwap;
      end
      StDnSwap: begin
        wr_en = 1'b1;
        if (cmp_lt) begin
          wr_data = child_q;
          pos_d   = cidx_q;
          state_d = StDnRead;
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      pos_q    <= '0;
      cidx_q   <= '0;
      key_q    <= '0;
      child_q  <= '0;
      status_q <= mhpq_pkg::StatusOk;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      cidx_q   <= cidx_d;
      key_q    <= key_d;
      child_q  <= child_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      heap_mem_q[wr_addr] <= wr_data;
    end
    rd0_q <= heap_mem_q[rd0_addr];
    rd1_q <= heap_mem_q[rd1_addr];
  end

  // keep a copy of the root so the minimum needs no extra read
  always_ff @(posedge clk_i) begin
    if (wr_en && (wr_addr == '0)) begin
      root_q <= wr_data;
    end
  end

  assign idle_o              = (state_q == StIdle);
  assign res_valid_o         = (state_q == StDone);
  assign res_o.smallest      = (count_q != '0) ? FieldW'(root_q) : '0;
  assign res_o.heap_empty    = (count_q == '0);
  assign res_o.entry_count   = CountW'(count_q);
  assign res_o.status        = status_q;

endmodule

/* rtl/core/min_heap_priority_queue.sv */
// Min-heap priority queue top level: command intake, heap engine, result register.
// Insert: the new key sifts up from the end of the heap toward the root.
// Remove: the last entry is moved to the root and sifts down; removing the only entry empties the heap.
// Full insert or empty remove: status only, heap unchanged.
// One word at a time; the next is accepted the cycle after the result enters the output register.
// Reset clears the count, control and output registers; the heap store is not cleared.
module min_heap_priority_queue #(
  parameter int CAPACITY  = 1024,
  parameter int KEY_BYTES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpq_in_if.sink     in_i,
  mhpq_out_if.source  out_o
);

  logic              eng_idle;
  logic              eng_valid;
  logic              eng_ready;
  logic              start;
  mhpq_pkg::result_t eng_res;
  mhpq_pkg::result_t res_q;
  logic              out_valid_q;

  assign start     = in_i.valid && in_i.ready;
  assign in_i.ready = eng_idle;
  assign eng_ready = !out_valid_q || out_o.ready;

  mhpq_engine #(
    .CAPACITY  (CAPACITY),
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (mhpq_pkg::cmd_e'(in_i.cmd)),
    .key_i       (in_i.key),
    .idle_o      (eng_idle),
    .res_valid_o (eng_valid),
    .res_ready_i (eng_ready),
    .res_o       (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else if (eng_valid && eng_ready) begin
      out_valid_q <= 1'b1;
      res_q       <= eng_res;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.smallest    = res_q.smallest;
  assign out_o.heap_empty  = res_q.heap_empty;
  assign out_o.entry_count = res_q.entry_count;
  assign out_o.status      = res_q.status;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !in_i.ready)
    else $error("heap took a word while busy");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == mhpq_pkg::StatusEmpty)) |-> out_o.heap_empty)
    else $error("remove-on-empty status with entries held");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == mhpq_pkg::StatusFull)) |-> !out_o.heap_empty)
    else $error("full status on an empty heap");

  a_empty_min_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.heap_empty) |-> (out_o.smallest == '0))
    else $error("nonzero minimum on an empty heap");

endmodule
